[hdl/brb_pkg.sv]
// Shared types and constants for the byte ring buffer.
package brb_pkg;

  // Field widths of the request and result channels
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 13;
  localparam int RCNT_W   = 7;
  localparam int DCNT_W   = 13;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 13;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register word index (paddr[2])
  localparam logic REG_CONSUME = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_SAVE    = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

endpackage

[hdl/brb_ifs.sv]
// Request and result channel interfaces for the byte ring buffer.
interface brb_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [brb_pkg::OP_W-1:0]     operation;
  logic [brb_pkg::BYTE_W-1:0]   data_byte;
  logic [brb_pkg::LEN_W-1:0]    save_length;
  logic                         first_of_save;
  logic [brb_pkg::RCNT_W-1:0]   read_count;
  logic [brb_pkg::DCNT_W-1:0]   discard_count;

  modport source (output valid, operation, data_byte, save_length, first_of_save,
                  read_count, discard_count, input ready);
  modport sink (input valid, operation, data_byte, save_length, first_of_save,
                read_count, discard_count, output ready);
endinterface

interface brb_res_if;
  logic                         valid;
  logic                         ready;
  logic [brb_pkg::STATUS_W-1:0] status;
  logic [brb_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_valid;
  logic                         last;
  logic [brb_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, status, out_byte, byte_valid, last, fill_count,
                  input ready);
  modport sink (input valid, status, out_byte, byte_valid, last, fill_count,
                output ready);
endinterface

[hdl/byte_ring_buffer_bulk_ops.sv]
// Byte ring buffer with bulk save, read and discard, top level.
//
//   channel   role    handshake             carries
//   cmd       sink    valid/ready           operation and its operands
//   res       source  valid/ready           status, byte, last, fill count
//   apb       slave   psel/penable, pready  consume_on_read at offset 0
//
// Save, discard and invalid requests give one result each.
// A read of n bytes holds the request side until its last byte is loaded: the single
// registered read port of the byte store streams a byte a cycle while results drain.
// Reset (rst, synchronous) empties the queue; the byte store is not cleared.
// A stalled result register holds the request side and the read stream.
module byte_ring_buffer_bulk_ops #(
  parameter int RING_BYTES = 4096,
  parameter int MAX_READ   = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  brb_cmd_if.sink                        cmd,
  brb_res_if.source                      res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brb_pkg::APB_AW-1:0]     paddr,
  input  logic [brb_pkg::APB_DW-1:0]     pwdata,
  output logic [brb_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int IW = $clog2(RING_BYTES);
  localparam int CW = $clog2(RING_BYTES + 1);
  localparam int SW = CW + 1;
  localparam int WW = (SW > brb_pkg::LEN_W) ? SW : brb_pkg::LEN_W;
  localparam int RW = $clog2(MAX_READ + 1);

  typedef enum logic {S_IDLE, S_STREAM} state_t;

  state_t                       state;
  logic [IW-1:0]                head;
  logic [CW-1:0]                count;
  logic                         burst;
  logic                         consume;
  logic [IW-1:0]                rd_ptr;
  logic [RW-1:0]                remaining;
  logic                         rd_pend;
  logic                         rd_last;
  logic [brb_pkg::BYTE_W-1:0]   mem_q;
  logic [brb_pkg::BYTE_W-1:0]   ring [RING_BYTES];

  logic                         res_valid;
  brb_pkg::status_t             res_status;
  logic [brb_pkg::BYTE_W-1:0]   res_byte;
  logic                         res_bvalid;
  logic                         res_last;
  logic [brb_pkg::FILL_W-1:0]   res_fill;

  logic                         out_free;
  logic                         accept;
  brb_pkg::op_t                 op;
  logic                         full;
  logic [WW-1:0]                count_w;
  logic [WW-1:0]                room_w;
  logic [WW-1:0]                slen_w;
  logic [brb_pkg::RCNT_W-1:0]   rsat;
  logic [WW-1:0]                rd_n_w;
  logic [SW-1:0]                wsum;
  logic [IW-1:0]                waddr;
  logic [WW-1:0]                drop_n;
  logic [SW-1:0]                dsum;
  logic [IW-1:0]                drop_head;
  logic [CW-1:0]                drop_count;
  logic [IW-1:0]                head_next;
  logic [CW-1:0]                count_next;
  logic                         burst_next;
  brb_pkg::status_t             st;
  logic                         mem_we;
  logic                         start_stream;
  logic                         issue;
  logic                         load_byte;
  logic                         res_load;
  logic [IW-1:0]                ptr_inc;
  logic                         cfg_wr;

  // Handshakes
  assign out_free  = !res_valid || res.ready;
  assign cmd.ready = (state == S_IDLE) && out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign op        = brb_pkg::op_t'(cmd.operation);

  // Room and length checks in a common width
  assign full    = (count == CW'(RING_BYTES));
  assign count_w = WW'(count);
  assign room_w  = WW'(RING_BYTES) - count_w;
  assign slen_w  = WW'(cmd.save_length);

  // Read length: saturate, then cut to the held bytes
  assign rsat   = (cmd.read_count > brb_pkg::RCNT_W'(MAX_READ)) ?
                  brb_pkg::RCNT_W'(MAX_READ) : cmd.read_count;
  assign rd_n_w = (WW'(rsat) > count_w) ? count_w : WW'(rsat);

  // Save address: tail of the queue, wrapped
  assign wsum  = SW'(head) + SW'(count);
  assign waddr = (wsum >= SW'(RING_BYTES)) ? IW'(wsum - SW'(RING_BYTES)) : IW'(wsum);

  // Drop from the head; empty queue restarts at zero
  assign drop_n = (op == brb_pkg::OP_READ) ? rd_n_w : WW'(cmd.discard_count);
  assign dsum   = SW'(head) + SW'(drop_n);
  always_comb begin
    if (count_w > drop_n) begin
      drop_head  = (dsum >= SW'(RING_BYTES)) ? IW'(dsum - SW'(RING_BYTES)) : IW'(dsum);
      drop_count = count - CW'(drop_n);
    end else begin
      drop_head  = '0;
      drop_count = '0;
    end
  end

  // Decode one request
  always_comb begin
    head_next    = head;
    count_next   = count;
    burst_next   = burst;
    st           = brb_pkg::ST_OK;
    mem_we       = 1'b0;
    start_stream = 1'b0;
    unique case (op)
      brb_pkg::OP_SAVE: begin
        if (cmd.first_of_save) begin
          burst_next = 1'b0;
          if (full) begin
            st = brb_pkg::ST_FULL;
          end else if (cmd.save_length == '0) begin
            st = brb_pkg::ST_INVALID;
          end else if (slen_w > room_w) begin
            st = brb_pkg::ST_TOO_LONG;
          end else begin
            burst_next = 1'b1;
            mem_we     = 1'b1;
          end
        end else if (!burst) begin
          st = brb_pkg::ST_INVALID;
        end else if (full) begin
          burst_next = 1'b0;
          st         = brb_pkg::ST_FULL;
        end else begin
          mem_we = 1'b1;
        end
        if (mem_we) begin
          count_next = count + CW'(1);
        end
      end
      brb_pkg::OP_READ: begin
        if (cmd.read_count == '0) begin
          st = brb_pkg::ST_INVALID;
        end else if (rd_n_w != '0) begin
          start_stream = 1'b1;
          if (consume) begin
            head_next  = drop_head;
            count_next = drop_count;
          end
        end
      end
      brb_pkg::OP_DISCARD: begin
        if (cmd.discard_count != '0) begin
          head_next  = drop_head;
          count_next = drop_count;
        end
      end
      default: begin
        st = brb_pkg::ST_INVALID;
      end
    endcase
  end

  // Read stream: issue while the data register is free or being emptied
  assign issue     = (state == S_STREAM) && (remaining != '0) && (!rd_pend || out_free);
  assign load_byte = rd_pend && out_free;
  assign ptr_inc   = (rd_ptr == IW'(RING_BYTES - 1)) ? '0 : rd_ptr + IW'(1);

  // Result register loads this cycle
  assign res_load = ((state == S_IDLE) && accept && !start_stream) ||
                    ((state == S_STREAM) && load_byte);

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      ring[waddr] <= cmd.data_byte;
    end
    if (issue) begin
      mem_q <= ring[rd_ptr];
    end
  end

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == brb_pkg::REG_CONSUME) ?
                  {{(brb_pkg::APB_DW-1){1'b0}}, consume} : '0;

  // Control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      burst     <= 1'b0;
      consume   <= 1'b0;
      remaining <= '0;
      rd_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_wr && (paddr[2] == brb_pkg::REG_CONSUME)) begin
        consume <= pwdata[0];
      end
      if (res_valid && res.ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            head  <= head_next;
            count <= count_next;
            burst <= burst_next;
            if (start_stream) begin
              state     <= S_STREAM;
              rd_ptr    <= head;
              remaining <= RW'(rd_n_w);
            end else begin
              res_valid  <= 1'b1;
              res_status <= st;
              res_byte   <= '0;
              res_bvalid <= 1'b0;
              res_last   <= 1'b1;
              res_fill   <= brb_pkg::FILL_W'(count_next);
            end
          end
        end
        S_STREAM: begin
          if (issue) begin
            rd_ptr    <= ptr_inc;
            remaining <= remaining - RW'(1);
            rd_pend   <= 1'b1;
            rd_last   <= (remaining == RW'(1));
          end else if (load_byte) begin
            rd_pend <= 1'b0;
          end
          if (load_byte) begin
            res_valid  <= 1'b1;
            res_status <= brb_pkg::ST_OK;
            res_byte   <= mem_q;
            res_bvalid <= 1'b1;
            res_last   <= rd_last;
            res_fill   <= brb_pkg::FILL_W'(count);
            if (rd_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the result channel
  assign res.valid      = res_valid;
  assign res.status     = res_status;
  assign res.out_byte   = res_byte;
  assign res.byte_valid = res_bvalid;
  assign res.last       = res_last;
  assign res.fill_count = res_fill;

endmodule

[hdl/brb_checker.sv]
// Port-level checks for the byte ring buffer, bound to the top level.
module brb_checker #(
  parameter int RING_BYTES = 4096
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           valid,
  input logic                           ready,
  input logic [brb_pkg::STATUS_W-1:0]   status,
  input logic [brb_pkg::BYTE_W-1:0]     out_byte,
  input logic                           byte_valid,
  input logic                           last,
  input logic [brb_pkg::FILL_W-1:0]     fill_count
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> $stable(out_byte) && $stable(byte_valid) && $stable(last))
    else $error("stalled result changed");

  // A result without a byte closes its request and carries a zero byte
  a_no_byte: assert property (@(posedge clk) disable iff (rst)
    valid && !byte_valid |-> last && (out_byte == '0))
    else $error("byteless result malformed");

  // Read bytes always report success
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    valid && byte_valid |-> (status == brb_pkg::ST_OK))
    else $error("read byte with error status");

  // Fill never exceeds the store
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (32'(fill_count) <= 32'(RING_BYTES)))
    else $error("fill count beyond store size");

endmodule

bind byte_ring_buffer_bulk_ops brb_checker #(.RING_BYTES(RING_BYTES)) u_brb_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (res.valid),
  .ready      (res.ready),
  .status     (res.status),
  .out_byte   (res.out_byte),
  .byte_valid (res.byte_valid),
  .last       (res.last),
  .fill_count (res.fill_count)
);

[test/byte_ring_buffer_bulk_ops_tb.sv]
// Self-checking testbench for the byte ring buffer: directed table, then random phases.
`timescale 1ns / 1ps

module byte_ring_buffer_bulk_ops_tb;

  localparam int RING_BYTES       = 4096;
  localparam int MAX_READ         = 64;
  localparam int GAP_MAX          = 16;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 4;
  localparam int RANDOM_PER_PHASE = 32;
  localparam logic [brb_pkg::APB_AW-1:0] CONSUME_ADDR = {brb_pkg::REG_CONSUME, 2'b00};

  typedef struct {
    brb_pkg::op_t                op;
    logic [brb_pkg::BYTE_W-1:0]  data;
    logic [brb_pkg::LEN_W-1:0]   slen;
    logic                        first;
    logic [brb_pkg::RCNT_W-1:0]  rcnt;
    logic [brb_pkg::DCNT_W-1:0]  dcnt;
  } ring_req_t;

  typedef struct {
    brb_pkg::status_t            status;
    logic [brb_pkg::BYTE_W-1:0]  out_byte;
    logic                        byte_valid;
    logic                        last;
    logic [brb_pkg::FILL_W-1:0]  fill;
  } ring_res_t;

  // One line of the directed table; typed rows carry their single result
  typedef struct {
    ring_req_t        req;
    int               rep;
    bit               typed;
    brb_pkg::status_t status;
    int               fill;
    int               cfg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [brb_pkg::APB_AW-1:0]   paddr;
  logic [brb_pkg::APB_DW-1:0]   pwdata;
  logic [brb_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  brb_cmd_if cmd_ch ();
  brb_res_if res_ch ();

  byte_ring_buffer_bulk_ops #(
    .RING_BYTES (RING_BYTES),
    .MAX_READ   (MAX_READ)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Mirror of the buffer state
  logic [brb_pkg::BYTE_W-1:0] ring_mirror [RING_BYTES];
  int mirror_head    = 0;
  int mirror_held    = 0;
  bit mirror_burst   = 1'b0;
  bit mirror_consume = 1'b0;

  ring_res_t pending_results [$];
  ring_res_t step_results [$];
  stim_row_t directed_rows [$];

  // Typed expectation travelling with the request on offer
  logic                         row_typed;
  brb_pkg::status_t             row_status;
  logic [brb_pkg::FILL_W-1:0]   row_fill;

  int mismatch_count  = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int bytes_read      = 0;
  int max_fill        = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  bit cmd_nogap       = 1'b0;
  bit res_nogap       = 1'b0;

  task automatic report(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic ring_res_t ring_result(brb_pkg::status_t st,
                                            logic [brb_pkg::BYTE_W-1:0] b, logic v,
                                            logic l);
    ring_res_t r;
    r.status     = st;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.fill       = mirror_held[brb_pkg::FILL_W-1:0];
    return r;
  endfunction

  // Drop bytes from the head; empty resets the head
  function automatic void ring_drop(int n);
    if (n == 0) return;
    if (mirror_held > n) begin
      mirror_head = (mirror_head + n) % RING_BYTES;
      mirror_held -= n;
    end else begin
      mirror_head = 0;
      mirror_held = 0;
    end
  endfunction

  // Work out the results of one request and advance the mirror
  function automatic void ring_apply(ring_req_t r);
    int room;
    int n;
    int start;
    brb_pkg::status_t st;
    step_results.delete();
    room = RING_BYTES - mirror_held;
    case (r.op)
      brb_pkg::OP_SAVE: begin
        st = brb_pkg::ST_OK;
        if (r.first) begin
          mirror_burst = 1'b0;
          if (room < 1) st = brb_pkg::ST_FULL;
          else if (r.slen == 0) st = brb_pkg::ST_INVALID;
          else if (int'(r.slen) > room) st = brb_pkg::ST_TOO_LONG;
          else mirror_burst = 1'b1;
        end else if (!mirror_burst) begin
          st = brb_pkg::ST_INVALID;
        end else if (room < 1) begin
          mirror_burst = 1'b0;
          st = brb_pkg::ST_FULL;
        end
        if (st == brb_pkg::ST_OK) begin
          ring_mirror[(mirror_head + mirror_held) % RING_BYTES] = r.data;
          mirror_held++;
        end
        step_results.push_back(ring_result(st, '0, 1'b0, 1'b1));
      end
      brb_pkg::OP_READ: begin
        n = (int'(r.rcnt) > MAX_READ) ? MAX_READ : int'(r.rcnt);
        if (n > mirror_held) n = mirror_held;
        if (r.rcnt == 0) begin
          step_results.push_back(ring_result(brb_pkg::ST_INVALID, '0, 1'b0, 1'b1));
        end else if (n == 0) begin
          step_results.push_back(ring_result(brb_pkg::ST_OK, '0, 1'b0, 1'b1));
        end else begin
          start = mirror_head;
          if (mirror_consume) ring_drop(n);
          for (int i = 0; i < n; i++) begin
            step_results.push_back(ring_result(brb_pkg::ST_OK,
                                               ring_mirror[(start + i) % RING_BYTES],
                                               1'b1, i == n - 1));
          end
        end
      end
      brb_pkg::OP_DISCARD: begin
        ring_drop(int'(r.dcnt));
        step_results.push_back(ring_result(brb_pkg::ST_OK, '0, 1'b0, 1'b1));
      end
      default: begin
        step_results.push_back(ring_result(brb_pkg::ST_INVALID, '0, 1'b0, 1'b1));
      end
    endcase
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin : scoreboard
    ring_req_t req;
    ring_res_t want;
    ring_res_t typed_res;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        req.op    = brb_pkg::op_t'(cmd_ch.operation);
        req.data  = cmd_ch.data_byte;
        req.slen  = cmd_ch.save_length;
        req.first = cmd_ch.first_of_save;
        req.rcnt  = cmd_ch.read_count;
        req.dcnt  = cmd_ch.discard_count;
        ring_apply(req);
        if (row_typed) begin
          typed_res.status     = row_status;
          typed_res.out_byte   = '0;
          typed_res.byte_valid = 1'b0;
          typed_res.last       = 1'b1;
          typed_res.fill       = row_fill;
          pending_results.push_back(typed_res);
        end else begin
          foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (res_ch.byte_valid === 1'b1) bytes_read++;
        if (int'(res_ch.fill_count) > max_fill) max_fill = int'(res_ch.fill_count);
        if (pending_results.size() == 0) begin
          report($sformatf("result st=%0d byte=%02h with nothing expected",
                           res_ch.status, res_ch.out_byte));
        end else begin
          want = pending_results.pop_front();
          if ({res_ch.status, res_ch.out_byte, res_ch.byte_valid, res_ch.last,
               res_ch.fill_count} !== {want.status, want.out_byte, want.byte_valid,
                                       want.last, want.fill}) begin
            report($sformatf({"got st=%0d byte=%02h bv=%0b last=%0b fill=%0d, ",
                              "want st=%0d byte=%02h bv=%0b last=%0b fill=%0d"},
                             res_ch.status, res_ch.out_byte, res_ch.byte_valid, res_ch.last,
                             res_ch.fill_count, want.status, want.out_byte, want.byte_valid,
                             want.last, want.fill));
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when asked
  initial begin : result_sink
    int gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_served < hold_requests) begin
        hold_served++;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = res_nogap ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input ring_req_t r, input bit typed,
                              input brb_pkg::status_t st, input int fill);
    int gap;
    gap = cmd_nogap ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.operation     <= r.op;
    cmd_ch.data_byte     <= r.data;
    cmd_ch.save_length   <= r.slen;
    cmd_ch.first_of_save <= r.first;
    cmd_ch.read_count    <= r.rcnt;
    cmd_ch.discard_count <= r.dcnt;
    cmd_ch.valid         <= 1'b1;
    row_typed            <= typed;
    row_status           <= st;
    row_fill             <= fill[brb_pkg::FILL_W-1:0];
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    if (r.op != brb_pkg::OP_NONE) requests_sent++;
  endtask

  // Stop offering and wait for every expected result
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic apb_access(input bit wr, input logic [brb_pkg::APB_AW-1:0] addr,
                            input logic [brb_pkg::APB_DW-1:0] wdata,
                            output logic [brb_pkg::APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write consume_on_read while idle and read it back
  task automatic set_consume(input bit v);
    logic [brb_pkg::APB_DW-1:0] rd;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, CONSUME_ADDR, {{(brb_pkg::APB_DW-1){1'b0}}, v}, rd);
    mirror_consume = v;
    apb_access(1'b0, CONSUME_ADDR, '0, rd);
    if (rd !== {{(brb_pkg::APB_DW-1){1'b0}}, v}) begin
      report($sformatf("consume_on_read reads back %0h, want %0b", rd, v));
    end
  endtask

  task automatic add_row(input brb_pkg::op_t op, input int data, input int slen,
                         input bit first, input int rcnt, input int dcnt, input int rep,
                         input bit typed, input brb_pkg::status_t st, input int fill,
                         input int cfg);
    stim_row_t row;
    row.req.op    = op;
    row.req.data  = data[brb_pkg::BYTE_W-1:0];
    row.req.slen  = slen[brb_pkg::LEN_W-1:0];
    row.req.first = first;
    row.req.rcnt  = rcnt[brb_pkg::RCNT_W-1:0];
    row.req.dcnt  = dcnt[brb_pkg::DCNT_W-1:0];
    row.rep       = rep;
    row.typed     = typed;
    row.status    = st;
    row.fill      = fill;
    row.cfg       = cfg;
    directed_rows.push_back(row);
  endtask

  // Request with every field random; the caller fixes the ones that matter
  function automatic ring_req_t random_req(brb_pkg::op_t op);
    ring_req_t r;
    r.op    = op;
    r.data  = brb_pkg::BYTE_W'($urandom_range(0, 255));
    r.slen  = brb_pkg::LEN_W'($urandom_range(0, 8191));
    r.first = 1'($urandom_range(0, 1));
    r.rcnt  = brb_pkg::RCNT_W'($urandom_range(0, 127));
    r.dcnt  = brb_pkg::DCNT_W'($urandom_range(0, 8191));
    return r;
  endfunction

  initial begin : stimulus
    ring_req_t req;
    int kind;
    int len;
    int emit;
    int phase_start;
    bit paused;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.operation     <= brb_pkg::OP_NONE;
    cmd_ch.data_byte     <= '0;
    cmd_ch.save_length   <= '0;
    cmd_ch.first_of_save <= 1'b0;
    cmd_ch.read_count    <= '0;
    cmd_ch.discard_count <= '0;
    row_typed  <= 1'b0;
    row_status <= brb_pkg::ST_OK;
    row_fill   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // op, data, length, first, read, discard, repeat, typed, status, fill, register
    add_row(brb_pkg::OP_READ,    0,    0,    0, 5,   0,    1,  1, brb_pkg::ST_OK,       0, 0);
    add_row(brb_pkg::OP_READ,    0,    0,    0, 0,   0,    1,  1, brb_pkg::ST_INVALID,  0, -1);
    add_row(brb_pkg::OP_SAVE,    'h5A, 0,    0, 0,   0,    1,  1, brb_pkg::ST_INVALID,  0, -1);
    add_row(brb_pkg::OP_NONE,    'hFF, 8191, 1, 127, 8191, 1,  1, brb_pkg::ST_INVALID,  0, -1);
    add_row(brb_pkg::OP_DISCARD, 0,    0,    0, 0,   0,    1,  1, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_DISCARD, 0,    0,    0, 0,   8191, 1,  1, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_SAVE,    1,    0,    1, 0,   0,    1,  1, brb_pkg::ST_INVALID,  0, -1);
    add_row(brb_pkg::OP_SAVE,    2,    8191, 1, 0,   0,    1,  1, brb_pkg::ST_TOO_LONG, 0, -1);
    add_row(brb_pkg::OP_SAVE,    3,    4097, 1, 0,   0,    1,  1, brb_pkg::ST_TOO_LONG, 0, -1);
    // a burst that claims the whole ring, cut short
    add_row(brb_pkg::OP_SAVE,    0,    4096, 1, 0,   0,    12, 0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_READ,    0,    0,    0, 127, 0,    1,  0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_DISCARD, 0,    0,    0, 0,   5,    1,  0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_SAVE,    'hFF, 2,    1, 0,   0,    1,  0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_SAVE,    'h00, 0,    0, 0,   0,    1,  0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_READ,    0,    0,    0, 3,   0,    1,  0, brb_pkg::ST_OK,       0, -1);
    add_row(brb_pkg::OP_READ,    0,    0,    0, 64,  0,    1,  0, brb_pkg::ST_OK,       0, 1);
    add_row(brb_pkg::OP_READ,    0,    0,    0, 3,   0,    1,  1, brb_pkg::ST_OK,       0, -1);

    // Walk the directed table; long bursts go without gaps
    foreach (directed_rows[r]) begin
      if (directed_rows[r].cfg >= 0) set_consume(directed_rows[r].cfg[0]);
      cmd_nogap = (directed_rows[r].rep > 1);
      res_nogap = (directed_rows[r].rep > 1);
      for (int k = 0; k < directed_rows[r].rep; k++) begin
        req = directed_rows[r].req;
        if (k > 0) req.first = 1'b0;
        if (directed_rows[r].rep > 1) req.data = brb_pkg::BYTE_W'($urandom_range(0, 255));
        send_request(req, directed_rows[r].typed, directed_rows[r].status,
                     directed_rows[r].fill);
      end
    end

    // Random phases, alternating consume_on_read
    for (int phase = 0; phase < 4; phase++) begin
      set_consume(phase % 2 == 1);
      // hold the result side off while requests keep coming
      if (phase == 1) hold_requests <= hold_requests + 1;
      phase_start = requests_sent;
      paused = 1'b0;
      while (requests_sent - phase_start < RANDOM_PER_PHASE) begin
        if ((requests_sent - phase_start) % 10 == 0) begin
          cmd_nogap = ($urandom_range(0, 3) == 0);
          res_nogap = ($urandom_range(0, 3) == 0);
        end
        if (phase == 2 && !paused && requests_sent - phase_start >= 16) begin
          paused = 1'b1;
          wait_drained();
        end
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          // well-formed burst, now and then too long or interrupted
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 400) : $urandom_range(1, 12);
          emit = (len > 16) ? 16 : len;
          for (int k = 0; k < emit; k++) begin
            req = random_req(brb_pkg::OP_SAVE);
            req.first = (k == 0);
            if (k == 0) req.slen = len[brb_pkg::LEN_W-1:0];
            send_request(req, 1'b0, brb_pkg::ST_OK, 0);
            if ($urandom_range(0, 9) == 0) begin
              send_request(random_req(brb_pkg::OP_READ), 1'b0, brb_pkg::ST_OK, 0);
            end
          end
        end else if (kind < 65) begin
          req = random_req(brb_pkg::OP_READ);
          if ($urandom_range(0, 7) != 0) req.rcnt = brb_pkg::RCNT_W'($urandom_range(1, 16));
          send_request(req, 1'b0, brb_pkg::ST_OK, 0);
        end else if (kind < 80) begin
          req = random_req(brb_pkg::OP_DISCARD);
          if ($urandom_range(0, 7) != 0) req.dcnt = brb_pkg::DCNT_W'($urandom_range(0, 6));
          send_request(req, 1'b0, brb_pkg::ST_OK, 0);
        end else begin
          // noise: unused operation, stray byte, or a first byte with any length
          case ($urandom_range(0, 2))
            0: req = random_req(brb_pkg::OP_NONE);
            1: begin
              req = random_req(brb_pkg::OP_SAVE);
              req.first = 1'b0;
            end
            default: begin
              req = random_req(brb_pkg::OP_SAVE);
              req.first = 1'b1;
            end
          endcase
          send_request(req, 1'b0, brb_pkg::ST_OK, 0);
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("Run covered %0d requests and %0d results, %0d of them read bytes;",
             requests_sent, results_checked, bytes_read);
    $display("fill peaked at %0d, with consume_on_read both off and on, %0d mismatches.",
             max_fill, mismatch_count);
    if (mismatch_count == 0) begin
      $display("byte_ring_buffer_bulk_ops test passed");
    end else begin
      $display("byte_ring_buffer_bulk_ops test failed");
    end
    $finish;
  end

  // Guard against a hang
  initial begin : watchdog
    #40_000_000;
    $display("byte_ring_buffer_bulk_ops test failed");
    $finish;
  end

endmodule
